// ===== hw/rtl/s3f_pkg.sv =====
// shared constants, register codes and types of the symmetric 3x3 image filter
`default_nettype none

package s3f_pkg;

  // fixed field widths
  localparam int PIX_W   = 8;
  localparam int COEF_W  = 16;
  localparam int SHIFT_W = 5;
  localparam int FW_W    = 12;
  localparam int FH_W    = 13;

  // default frame limits
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;

  // register port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_COEF_CENTER  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_EDGE    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_CORNER  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_AMOUNT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

  // queue depths
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 8;

  // arithmetic widths
  localparam int ESUM_W = PIX_W + 2;
  localparam int PC_W   = COEF_W + PIX_W + 1;
  localparam int PE_W   = COEF_W + ESUM_W + 1;
  localparam int SUM_W  = 32;

  // what the front tells the back about one request
  typedef struct packed {
    logic is_flush;
    logic emit;
    logic interior;
    logic last;
    logic use_mid;
  } cmd_flags_t;

  localparam int FLAGS_W = $bits(cmd_flags_t);

  // live arithmetic settings
  typedef struct packed {
    logic [COEF_W-1:0]  coef_center;
    logic [COEF_W-1:0]  coef_edge;
    logic [COEF_W-1:0]  coef_corner;
    logic [SHIFT_W-1:0] shift_amount;
  } coef_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/s3f_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module s3f_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/s3f_fifo.sv =====
// small register fifo used for the request queue and the result queue
`default_nettype none

module s3f_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/s3f_front.sv =====
// front end: accepts pixels and flushes, tracks frame position, classifies requests
`default_nettype none

module s3f_front import s3f_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [PIX_W-1:0]             in_tdata,
  input  wire logic                         in_flush,
  input  wire logic [FW_W-1:0]              frame_width,
  input  wire logic [FH_W-1:0]              frame_height,
  input  wire logic                         q_full,
  output logic                              q_push,
  output cmd_flags_t                        q_flags,
  output logic      [PIX_W-1:0]             q_pixel,
  output logic      [$clog2(MAX_WIDTH)-1:0] q_addr
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int WW1 = WW + 1;
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int HW1 = HW + 1;

  logic          active_r, active_nxt;
  logic          in_done_r, in_done_nxt;
  logic          out_done_r, out_done_nxt;
  logic [WW-1:0] cur_w_r, cur_w_nxt;
  logic [HW-1:0] cur_h_r, cur_h_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [RW-1:0] out_row_r, out_row_nxt;

  logic          accept;
  logic          new_frame;
  logic [WW-1:0] clamp_w;
  logic [HW-1:0] clamp_h;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [CW-1:0] eff_in_col;
  logic [RW-1:0] eff_in_row;
  logic [CW-1:0] eff_out_col;
  logic [RW-1:0] eff_out_row;
  logic          eff_out_done;
  logic          produce;
  logic          flush_ok;
  logic          emitting;
  logic          last_pos;
  logic          last_row;
  logic          interior;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // frame size as latched at the first pixel, zero taken as one, sizes above the maximum clamped to it
  always_comb begin
    if (frame_width == '0) begin
      clamp_w = WW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      clamp_w = WW'(MAX_WIDTH);
    end else begin
      clamp_w = WW'(frame_width);
    end
    if (frame_height == '0) begin
      clamp_h = HW'(1);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      clamp_h = HW'(MAX_HEIGHT);
    end else begin
      clamp_h = HW'(frame_height);
    end
  end

  // position as seen by this request, a pixel after a finished frame restarts
  assign new_frame    = !in_flush && (!active_r || in_done_r);
  assign eff_w        = new_frame ? clamp_w : cur_w_r;
  assign eff_h        = new_frame ? clamp_h : cur_h_r;
  assign eff_in_col   = new_frame ? '0 : in_col_r;
  assign eff_in_row   = new_frame ? '0 : in_row_r;
  assign eff_out_col  = new_frame ? '0 : out_col_r;
  assign eff_out_row  = new_frame ? '0 : out_row_r;
  assign eff_out_done = new_frame ? 1'b0 : out_done_r;

  // classification
  assign produce  = (eff_in_row >= RW'(2)) ||
                    ((eff_in_row == RW'(1)) && (eff_in_col >= CW'(1)));
  assign flush_ok = active_r && in_done_r && !out_done_r;
  assign emitting = in_flush ? flush_ok : (produce && !eff_out_done);
  assign last_row = (HW'(eff_out_row) + HW'(1) == eff_h);
  assign last_pos = last_row && (WW'(eff_out_col) + WW'(1) == eff_w);
  assign interior = (eff_out_row >= RW'(1)) &&
                    (HW1'(eff_out_row) + HW1'(2) <= HW1'(eff_h)) &&
                    (eff_out_col >= CW'(1)) &&
                    (WW1'(eff_out_col) + WW1'(2) <= WW1'(eff_w));

  // request to the queue
  always_comb begin
    q_push           = accept && (!in_flush || flush_ok);
    q_pixel          = in_tdata;
    q_addr           = in_flush ? out_col_r : eff_in_col;
    q_flags.is_flush = in_flush;
    q_flags.emit     = emitting;
    q_flags.interior = !in_flush && interior;
    q_flags.last     = last_pos;
    q_flags.use_mid  = last_row;
  end

  // position counters
  always_comb begin
    active_nxt   = active_r;
    in_done_nxt  = in_done_r;
    out_done_nxt = out_done_r;
    cur_w_nxt    = cur_w_r;
    cur_h_nxt    = cur_h_r;
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    if (accept) begin
      out_col_nxt  = eff_out_col;
      out_row_nxt  = eff_out_row;
      out_done_nxt = eff_out_done;
      // input side advances on pixels only
      if (!in_flush) begin
        active_nxt  = 1'b1;
        cur_w_nxt   = eff_w;
        cur_h_nxt   = eff_h;
        in_done_nxt = new_frame ? 1'b0 : in_done_r;
        in_row_nxt  = eff_in_row;
        if (WW'(eff_in_col) + WW'(1) >= eff_w) begin
          in_col_nxt = '0;
          if (HW'(eff_in_row) + HW'(1) >= eff_h) begin
            in_done_nxt = 1'b1;
          end else begin
            in_row_nxt = eff_in_row + RW'(1);
          end
        end else begin
          in_col_nxt = eff_in_col + CW'(1);
        end
      end
      // output side advances per result
      if (emitting) begin
        if (last_pos) begin
          out_done_nxt = 1'b1;
        end else if (WW'(eff_out_col) + WW'(1) >= eff_w) begin
          out_col_nxt = '0;
          out_row_nxt = eff_out_row + RW'(1);
        end else begin
          out_col_nxt = eff_out_col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      in_done_r  <= 1'b0;
      out_done_r <= 1'b0;
      cur_w_r    <= WW'(1);
      cur_h_r    <= HW'(1);
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
    end else begin
      active_r   <= active_nxt;
      in_done_r  <= in_done_nxt;
      out_done_r <= out_done_nxt;
      cur_w_r    <= cur_w_nxt;
      cur_h_r    <= cur_h_nxt;
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/s3f_back.sv =====
// back end: line stores, window, weighted sum pipeline and result queue
`default_nettype none

module s3f_back import s3f_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire coef_cfg_t                    cfg,
  input  wire logic                         q_valid,
  input  wire cmd_flags_t                   q_flags,
  input  wire logic [PIX_W-1:0]             q_pixel,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] q_addr,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [PIX_W-1:0]             out_pixel,
  output logic                              out_last
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RES_W = $clog2(OUT_DEPTH + 1);
  localparam int OQ_W  = PIX_W + 1;

  // issue stage with result credits
  logic [RES_W-1:0] reserved_r, reserved_nxt;
  logic             out_pop;
  logic             issue_emit;

  assign q_pop      = q_valid && (!q_flags.emit || (reserved_r < RES_W'(OUT_DEPTH)));
  assign issue_emit = q_pop && q_flags.emit;
  assign out_pop    = out_valid && out_ready;
  assign reserved_nxt = reserved_r + RES_W'(issue_emit) - RES_W'(out_pop);

  // stage 1 registers (ram read in flight)
  logic             s1_v_r;
  cmd_flags_t       s1_flags_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [CW-1:0]    s1_addr_r;

  // last line store write, for a read that raced it
  logic             wb_v_r;
  logic [CW-1:0]    wb_addr_r;
  logic [PIX_W-1:0] wb_up_r;
  logic [PIX_W-1:0] wb_mid_r;

  logic [PIX_W-1:0] ram_up_rd;
  logic [PIX_W-1:0] ram_mid_rd;
  logic [PIX_W-1:0] top_v;
  logic [PIX_W-1:0] mid_v;
  logic             ram_we;
  logic [PIX_W-1:0] copy_nxt;

  logic [PIX_W-1:0] window_r [9];
  logic [PIX_W-1:0] window_nxt [9];

  // line stores
  s3f_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (s1_addr_r),
    .wdata   (mid_v),
    .raddr   (q_addr),
    .rdata_r (ram_up_rd)
  );

  s3f_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (s1_addr_r),
    .wdata   (s1_pix_r),
    .raddr   (q_addr),
    .rdata_r (ram_mid_rd)
  );

  // stage 1: forward the previous write, shift window, pick the copy value
  always_comb begin
    top_v  = (wb_v_r && (wb_addr_r == s1_addr_r)) ? wb_up_r : ram_up_rd;
    mid_v  = (wb_v_r && (wb_addr_r == s1_addr_r)) ? wb_mid_r : ram_mid_rd;
    ram_we = s1_v_r && !s1_flags_r.is_flush;
    window_nxt = window_r;
    if (ram_we) begin
      window_nxt[0] = window_r[1];
      window_nxt[1] = window_r[2];
      window_nxt[2] = top_v;
      window_nxt[3] = window_r[4];
      window_nxt[4] = window_r[5];
      window_nxt[5] = mid_v;
      window_nxt[6] = window_r[7];
      window_nxt[7] = window_r[8];
      window_nxt[8] = s1_pix_r;
    end
    if (s1_flags_r.is_flush) begin
      copy_nxt = s1_flags_r.use_mid ? mid_v : top_v;
    end else begin
      copy_nxt = window_r[5];
    end
  end

  // stage 2 registers (window holds this request's neighbourhood)
  logic             s2_v_r;
  logic             s2_interior_r;
  logic             s2_last_r;
  logic [PIX_W-1:0] s2_copy_r;

  // stage 3 registers: neighbour sums
  logic              s3_v_r;
  logic              s3_interior_r;
  logic              s3_last_r;
  logic [PIX_W-1:0]  s3_copy_r;
  logic [PIX_W-1:0]  s3_center_r;
  logic [ESUM_W-1:0] s3_esum_r;
  logic [ESUM_W-1:0] s3_ksum_r;
  logic [ESUM_W-1:0] esum_nxt;
  logic [ESUM_W-1:0] ksum_nxt;

  assign esum_nxt = ESUM_W'(window_r[1]) + ESUM_W'(window_r[3]) +
                    ESUM_W'(window_r[5]) + ESUM_W'(window_r[7]);
  assign ksum_nxt = ESUM_W'(window_r[0]) + ESUM_W'(window_r[2]) +
                    ESUM_W'(window_r[6]) + ESUM_W'(window_r[8]);

  // stage 4 registers: weighted terms
  logic                    s4_v_r;
  logic                    s4_interior_r;
  logic                    s4_last_r;
  logic [PIX_W-1:0]        s4_copy_r;
  logic signed [PC_W-1:0]  s4_pc_r;
  logic signed [PE_W-1:0]  s4_pe_r;
  logic signed [PE_W-1:0]  s4_pk_r;

  logic signed [COEF_W-1:0] kc;
  logic signed [COEF_W-1:0] ke;
  logic signed [COEF_W-1:0] kk;
  logic signed [PIX_W:0]    cen_s;
  logic signed [ESUM_W:0]   esum_s;
  logic signed [ESUM_W:0]   ksum_s;
  logic signed [PC_W-1:0]   pc_nxt;
  logic signed [PE_W-1:0]   pe_nxt;
  logic signed [PE_W-1:0]   pk_nxt;

  assign kc     = cfg.coef_center;
  assign ke     = cfg.coef_edge;
  assign kk     = cfg.coef_corner;
  assign cen_s  = {1'b0, s3_center_r};
  assign esum_s = {1'b0, s3_esum_r};
  assign ksum_s = {1'b0, s3_ksum_r};
  assign pc_nxt = kc * cen_s;
  assign pe_nxt = ke * esum_s;
  assign pk_nxt = kk * ksum_s;

  // final sum, arithmetic shift, low byte or copy
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] shifted;
  logic [PIX_W-1:0]        result_pix;

  assign sum        = SUM_W'(s4_pc_r) + SUM_W'(s4_pe_r) + SUM_W'(s4_pk_r);
  assign shifted    = sum >>> cfg.shift_amount;
  assign result_pix = s4_interior_r ? shifted[PIX_W-1:0] : s4_copy_r;

  // result queue
  logic [OQ_W-1:0] oq_rdata;
  logic            oq_full;
  logic            oq_empty;

  s3f_fifo #(.WIDTH(OQ_W), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (s4_v_r),
    .wdata ({s4_last_r, result_pix}),
    .pop   (out_pop),
    .rdata (oq_rdata),
    .full  (oq_full),
    .empty (oq_empty)
  );

  assign out_valid = !oq_empty;
  assign out_pixel = oq_rdata[PIX_W-1:0];
  assign out_last  = oq_rdata[PIX_W] && !oq_full | oq_rdata[PIX_W];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= '0;
      s1_v_r     <= 1'b0;
      wb_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
      s4_v_r     <= 1'b0;
      window_r   <= '{default: '0};
    end else begin
      reserved_r <= reserved_nxt;
      s1_v_r     <= q_pop;
      wb_v_r     <= ram_we;
      s2_v_r     <= s1_v_r && s1_flags_r.emit;
      s3_v_r     <= s2_v_r;
      s4_v_r     <= s3_v_r;
      window_r   <= window_nxt;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_flags_r    <= q_flags;
    s1_pix_r      <= q_pixel;
    s1_addr_r     <= q_addr;
    wb_addr_r     <= s1_addr_r;
    wb_up_r       <= mid_v;
    wb_mid_r      <= s1_pix_r;
    s2_interior_r <= s1_flags_r.interior;
    s2_last_r     <= s1_flags_r.last;
    s2_copy_r     <= copy_nxt;
    s3_interior_r <= s2_interior_r;
    s3_last_r     <= s2_last_r;
    s3_copy_r     <= s2_copy_r;
    s3_center_r   <= window_r[4];
    s3_esum_r     <= esum_nxt;
    s3_ksum_r     <= ksum_nxt;
    s4_interior_r <= s3_interior_r;
    s4_last_r     <= s3_last_r;
    s4_copy_r     <= s3_copy_r;
    s4_pc_r       <= pc_nxt;
    s4_pe_r       <= pe_nxt;
    s4_pk_r       <= pk_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/symmetric_3x3_image_filter.sv =====
// top level of the symmetric 3x3 image filter: register port, request queue, front and back
`default_nettype none

// Streaming 3x3 filter for 8-bit grayscale frames in raster order. One input
// request (a pixel, or a flush marked in in_tuser) is taken per clock while the
// request queue has room; the result queue lets the input keep flowing while
// out_tready is low, and the block stalls only once both queues are full.
// Each interior pixel becomes center*coef_center + edges*coef_edge +
// corners*coef_corner, shifted right arithmetically by shift_amount, low 8
// bits kept; border pixels pass through unchanged. Results trail the input
// stream by one row plus one pixel, so after the last pixel of a frame send
// frame_width+1 flush requests to drain it; out_tlast marks its last pixel.
// With a free output a request passes through the request queue, a line
// store read, the window, the neighbour sums, the three multipliers, and
// the sum and shift before its result appears in the result queue. The two
// line stores are MAX_WIDTH x 8 rams with one read and one write each clock,
// which sets the rate of one pixel per clock. No clearing pass runs after
// reset. Frame size is latched at the first pixel of each frame; the weights
// and the shift are used live and should be written only while idle.
module symmetric_3x3_image_filter import s3f_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [PIX_W-1:0]      in_tdata,   // [7:0] pixel_in
  input  wire logic [0:0]            in_tuser,   // [0] flush
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [PIX_W-1:0]      out_tdata,  // [7:0] pixel_out
  output logic                       out_tlast,  // frame_end
  // register port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int Q_W = CW + PIX_W + FLAGS_W;

  // configuration registers
  logic [COEF_W-1:0]    coef_center_r;
  logic [COEF_W-1:0]    coef_edge_r;
  logic [COEF_W-1:0]    coef_corner_r;
  logic [SHIFT_W-1:0]   shift_amount_r;
  logic [FW_W-1:0]      frame_width_r;
  logic [FH_W-1:0]      frame_height_r;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_center_r  <= '0;
      coef_edge_r    <= '0;
      coef_corner_r  <= '0;
      shift_amount_r <= '0;
      frame_width_r  <= FW_W'(MAX_WIDTH);
      frame_height_r <= FH_W'(1);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_COEF_CENTER:  coef_center_r  <= cfg_pwdata[COEF_W-1:0];
        REG_COEF_EDGE:    coef_edge_r    <= cfg_pwdata[COEF_W-1:0];
        REG_COEF_CORNER:  coef_corner_r  <= cfg_pwdata[COEF_W-1:0];
        REG_SHIFT_AMOUNT: shift_amount_r <= cfg_pwdata[SHIFT_W-1:0];
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_COEF_CENTER:  cfg_prdata = CFG_DATA_W'(coef_center_r);
      REG_COEF_EDGE:    cfg_prdata = CFG_DATA_W'(coef_edge_r);
      REG_COEF_CORNER:  cfg_prdata = CFG_DATA_W'(coef_corner_r);
      REG_SHIFT_AMOUNT: cfg_prdata = CFG_DATA_W'(shift_amount_r);
      REG_FRAME_WIDTH:  cfg_prdata = CFG_DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = CFG_DATA_W'(frame_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  coef_cfg_t coef_cfg;

  assign coef_cfg.coef_center  = coef_center_r;
  assign coef_cfg.coef_edge    = coef_edge_r;
  assign coef_cfg.coef_corner  = coef_corner_r;
  assign coef_cfg.shift_amount = shift_amount_r;

  // front end
  logic             fq_push;
  cmd_flags_t       fq_flags;
  logic [PIX_W-1:0] fq_pixel;
  logic [CW-1:0]    fq_addr;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic [Q_W-1:0]   q_rdata;
  cmd_flags_t       bq_flags;
  logic [PIX_W-1:0] bq_pixel;
  logic [CW-1:0]    bq_addr;

  s3f_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_flush     (in_tuser[0]),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .q_full       (q_full),
    .q_push       (fq_push),
    .q_flags      (fq_flags),
    .q_pixel      (fq_pixel),
    .q_addr       (fq_addr)
  );

  // request queue between front and back
  s3f_fifo #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_req_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata ({fq_addr, fq_pixel, fq_flags}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign bq_flags = q_rdata[FLAGS_W-1:0];
  assign bq_pixel = q_rdata[FLAGS_W +: PIX_W];
  assign bq_addr  = q_rdata[FLAGS_W + PIX_W +: CW];

  // back end
  s3f_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (coef_cfg),
    .q_valid   (!q_empty),
    .q_flags   (bq_flags),
    .q_pixel   (bq_pixel),
    .q_addr    (bq_addr),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== dv/s3f_filter_checker.sv =====
// result checker of the symmetric 3x3 image filter: follows the register writes, predicts every pixel and compares
module s3f_filter_checker import s3f_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // [7:0] pixel_in
  input  logic [0:0]            in_tuser,   // [0] flush
  // result stream
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [PIX_W-1:0]      out_tdata,  // [7:0] pixel_out
  input  logic                  out_tlast,  // frame_end
  // register port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  // to the testbench top
  output int                    failures,
  output int                    outstanding
);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } out_pixel_t;

  out_pixel_t due_pixels[$];
  out_pixel_t head;
  int         fault_cnt;

  // shadow of the registers
  logic [COEF_W-1:0]  w_center;
  logic [COEF_W-1:0]  w_side;
  logic [COEF_W-1:0]  w_diag;
  logic [SHIFT_W-1:0] shift_amt;
  logic [FW_W-1:0]    width_reg;
  logic [FH_W-1:0]    height_reg;

  // line stores, 3x3 window and raster positions of both sides
  logic [PIX_W-1:0] upper_line [MAX_WIDTH];
  logic [PIX_W-1:0] middle_line [MAX_WIDTH];
  logic [PIX_W-1:0] win [9];
  int unsigned      in_row, in_col, out_row, out_col, frm_w, frm_h;
  bit               in_frame, in_done, out_done;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic bit is_interior();
    return out_row >= 1 && out_row + 2 <= frm_h && out_col >= 1 && out_col + 2 <= frm_w;
  endfunction

  // weighted sum of the window, arithmetic shift, low byte kept
  function automatic logic [PIX_W-1:0] weighted_pixel();
    longint sides, diags, acc;
    sides = longint'(win[1]) + longint'(win[3]) + longint'(win[5]) + longint'(win[7]);
    diags = longint'(win[0]) + longint'(win[2]) + longint'(win[6]) + longint'(win[8]);
    acc = longint'($signed(w_center)) * longint'(win[4])
        + longint'($signed(w_side)) * sides
        + longint'($signed(w_diag)) * diags;
    acc = acc >>> shift_amt;
    return acc[PIX_W-1:0];
  endfunction

  // queue the pixel at the output position, then step along the raster
  function automatic void queue_pixel(logic [PIX_W-1:0] v);
    logic last;
    last = (out_row + 1 == frm_h) && (out_col + 1 == frm_w);
    due_pixels.push_back('{pixel: v, frame_end: last});
    if (last) begin
      out_done = 1'b1;
    end else if (out_col + 1 >= frm_w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endfunction

  function automatic void predict_request(logic [PIX_W-1:0] pix, logic flush);
    int unsigned      c;
    logic [PIX_W-1:0] above, level;
    bit               produce;
    // drain: the pending pixel still sits in a line store
    if (flush) begin
      if (in_frame && in_done && !out_done)
        queue_pixel((out_row + 1 == frm_h) ? middle_line[out_col % MAX_WIDTH]
                                           : upper_line[out_col % MAX_WIDTH]);
      return;
    end
    // first pixel of a frame latches its size
    if (!in_frame || in_done) begin
      frm_w    = clamp_size(width_reg, MAX_WIDTH);
      frm_h    = clamp_size(height_reg, MAX_HEIGHT);
      in_row   = 0;
      in_col   = 0;
      out_row  = 0;
      out_col  = 0;
      in_frame = 1'b1;
      in_done  = 1'b0;
      out_done = 1'b0;
    end
    c       = in_col % MAX_WIDTH;
    above   = upper_line[c];
    level   = middle_line[c];
    produce = in_row >= 2 || (in_row == 1 && in_col >= 1);
    upper_line[c]  = level;
    middle_line[c] = pix;
    // window moves one column left
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = above;
    win[5] = level;
    win[8] = pix;
    if (in_col + 1 >= frm_w) begin
      in_col = 0;
      if (in_row + 1 >= frm_h) in_done = 1'b1;
      else in_row++;
    end else begin
      in_col++;
    end
    if (produce && !out_done)
      queue_pixel(is_interior() ? weighted_pixel() : win[4]);
  endfunction

  function automatic void note_mismatch(string field, logic [PIX_W-1:0] want,
                                        logic [PIX_W-1:0] got);
    fault_cnt++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      w_center   = '0;
      w_side     = '0;
      w_diag     = '0;
      shift_amt  = '0;
      width_reg  = FW_W'(DEF_MAX_WIDTH);
      height_reg = FH_W'(1);
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      in_row   = 0;
      in_col   = 0;
      out_row  = 0;
      out_col  = 0;
      frm_w    = 1;
      frm_h    = 1;
      in_frame = 1'b0;
      in_done  = 1'b0;
      out_done = 1'b0;
      due_pixels.delete();
    end else begin
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_ADDR_W-1:2])
          REG_COEF_CENTER:  w_center   = cfg_pwdata[COEF_W-1:0];
          REG_COEF_EDGE:    w_side     = cfg_pwdata[COEF_W-1:0];
          REG_COEF_CORNER:  w_diag     = cfg_pwdata[COEF_W-1:0];
          REG_SHIFT_AMOUNT: shift_amt  = cfg_pwdata[SHIFT_W-1:0];
          REG_FRAME_WIDTH:  width_reg  = cfg_pwdata[FW_W-1:0];
          REG_FRAME_HEIGHT: height_reg = cfg_pwdata[FH_W-1:0];
          default: ;
        endcase
      end
      // results against the oldest expectation
      if (out_tvalid && out_tready) begin
        if (due_pixels.size() == 0) begin
          fault_cnt++;
          $display("%0t: result %0d (end %0b) with none expected", $time,
                   out_tdata, out_tlast);
        end else begin
          head = due_pixels.pop_front();
          if (head.pixel !== out_tdata) note_mismatch("pixel_out", head.pixel, out_tdata);
          if (head.frame_end !== out_tlast)
            note_mismatch("frame_end", PIX_W'(head.frame_end), PIX_W'(out_tlast));
        end
      end
      // accepted requests
      if (in_tvalid && in_tready) predict_request(in_tdata, in_tuser[0]);
    end
    failures    <= fault_cnt;
    outstanding <= due_pixels.size();
  end

endmodule

// ===== dv/testbench.sv =====
// testbench top of the symmetric 3x3 image filter: clock, reset, register set-up, pixel stimulus and verdict
module testbench;
  import s3f_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 750;
  localparam int CALM_ITEMS    = 120;
  localparam int SETTLE_CYCLES = 16;

  typedef enum int {FILL_RANDOM, FILL_WHITE, FILL_EXTREME, FILL_DIM} fill_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata;   // [7:0] pixel_in
  logic [0:0]            in_tuser;   // [0] flush
  logic                  out_tvalid;
  logic                  out_tready;
  logic [PIX_W-1:0]      out_tdata;  // [7:0] pixel_out
  logic                  out_tlast;  // frame_end
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int                    failures;
  int                    outstanding;

  bit              calm;
  int unsigned     cycles = 0;
  int unsigned     sent = 0;
  int unsigned     ready_left;
  logic [FW_W-1:0] width_set = FW_W'(DEF_MAX_WIDTH);
  logic [FH_W-1:0] height_set = FH_W'(1);

  symmetric_3x3_image_filter u_dut (.*);

  s3f_filter_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_tready <= 1'b1;
      ready_left <= 0;
    end else if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if ($urandom_range(2) == 0) begin
      out_tready <= 1'b0;
      ready_left <= $urandom_range(5);
    end else begin
      out_tready <= 1'b1;
      ready_left <= $urandom_range(11);
    end
  end

  function automatic int unsigned eff_size(int unsigned raw, int unsigned maxv);
    return (raw == 0) ? 1 : ((raw > maxv) ? maxv : raw);
  endfunction

  function automatic logic [PIX_W-1:0] fill_pixel(fill_t fill);
    case (fill)
      FILL_WHITE:   return 8'hFF;
      FILL_EXTREME: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      FILL_DIM:     return PIX_W'($urandom_range(3));
      default:      return PIX_W'($urandom());
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4, 5:    return COEF_W'($urandom_range(16)) - COEF_W'(8);
      default: return COEF_W'($urandom());
    endcase
  endfunction

  function automatic logic [SHIFT_W-1:0] pick_shift();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2, 3:    return SHIFT_W'($urandom_range(6));
      default: return SHIFT_W'($urandom());
    endcase
  endfunction

  function automatic logic [FW_W-1:0] pick_width();
    case ($urandom_range(9))
      0:       return '0;
      1:       return FW_W'($urandom_range(40, 11));
      default: return FW_W'($urandom_range(10, 1));
    endcase
  endfunction

  function automatic logic [FH_W-1:0] pick_height();
    case ($urandom_range(9))
      0:       return '0;
      1:       return FH_W'($urandom_range(12, 7));
      default: return FH_W'($urandom_range(6, 1));
    endcase
  endfunction

  // one request, with an optional idle burst ahead of it
  task automatic push_request(input logic [PIX_W-1:0] pix, input logic fl);
    if (!calm && $urandom_range(4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= fl;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // wait until every expected pixel is out and the pipeline is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_weights(input logic [COEF_W-1:0] w_center, input logic [COEF_W-1:0] w_side,
                             input logic [COEF_W-1:0] w_diag, input logic [SHIFT_W-1:0] shamt);
    write_reg(REG_COEF_CENTER, CFG_DATA_W'(w_center));
    write_reg(REG_COEF_EDGE, CFG_DATA_W'(w_side));
    write_reg(REG_COEF_CORNER, CFG_DATA_W'(w_diag));
    write_reg(REG_SHIFT_AMOUNT, CFG_DATA_W'(shamt));
  endtask

  task automatic set_frame(input logic [FW_W-1:0] fw, input logic [FH_W-1:0] fh);
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(fw));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(fh));
    width_set  = fw;
    height_set = fh;
  endtask

  task automatic random_setup();
    set_weights(pick_coef(), pick_coef(), pick_coef(), pick_shift());
    set_frame(pick_width(), pick_height());
  endtask

  // pixels of one frame, with stray early flushes and a possible mid-frame rewrite
  task automatic send_pixels(input int unsigned count, input fill_t fill,
                             input int unsigned split);
    for (int unsigned n = 0; n < count; n++) begin
      if (n == split && n != 0) begin
        settle();
        random_setup();
      end
      if ($urandom_range(19) == 0) push_request(PIX_W'($urandom()), 1'b1);
      push_request(fill_pixel(fill), 1'b0);
    end
  endtask

  task automatic flush_run(input int unsigned count);
    repeat (count) push_request(PIX_W'($urandom()), 1'b1);
  endtask

  task automatic random_frame();
    int unsigned fw, pixels, split, drains;
    fill_t       fill;
    calm <= (sent + CALM_ITEMS >= RANDOM_ITEMS);
    if ($urandom_range(1) == 0) begin
      settle();
      random_setup();
    end
    fw     = eff_size(width_set, DEF_MAX_WIDTH);
    pixels = fw * eff_size(height_set, DEF_MAX_HEIGHT);
    fill   = fill_t'($urandom_range(3));
    split  = ($urandom_range(4) == 0) ? $urandom_range(pixels - 1) : pixels;
    send_pixels(pixels, fill, split);
    // mostly a full drain, sometimes cut short so the next frame drops the rest
    if ($urandom_range(5) == 0) drains = $urandom_range(fw);
    else drains = fw + 1 + $urandom_range(1);
    flush_run(drains);
    sent += pixels + drains;
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    calm        <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // flush with no frame open
    push_request(8'h5A, 1'b1);
    settle();

    // 3x3 frame, extreme weights, early flush mid-frame, one flush too many
    set_weights(16'h7FFF, 16'h8000, 16'hFFFF, 5'd0);
    set_frame(12'd3, 13'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) push_request(8'hA5, 1'b1);
      push_request((i % 2 != 0) ? 8'h00 : 8'hFF, 1'b0);
    end
    flush_run(5);
    settle();

    // widest shift, opposite extremes, drain cut short
    set_weights(16'h8000, 16'h7FFF, 16'h0001, 5'd31);
    set_frame(12'd4, 13'd3);
    send_pixels(12, FILL_WHITE, 12);
    flush_run(2);
    settle();

    // size registers at zero, taken as one
    set_frame(12'd0, 13'd5);
    send_pixels(5, FILL_RANDOM, 5);
    flush_run(2);
    settle();
    set_frame(12'd7, 13'd0);
    send_pixels(7, FILL_EXTREME, 7);
    flush_run(8);

    // random frames, free-running at the end
    while (sent < RANDOM_ITEMS) random_frame();

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
